@@ sv/utf16_to_utf8_transcoder_macros.svh @@
// Assertion helpers, clocked on clk_i and idle while rst_ni is low.
`ifndef UTF16_TO_UTF8_TRANSCODER_MACROS_SVH
`define UTF16_TO_UTF8_TRANSCODER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define U16U8_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("u16u8 check failed");

// Consequent checked in the cycle after the antecedent.
`define U16U8_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("u16u8 check failed");

`endif

@@ sv/u16u8_pkg.sv @@
package u16u8_pkg;

  localparam logic [15:0] HiFirst = 16'hD800;
  localparam logic [15:0] HiLast  = 16'hDBFF;
  localparam logic [15:0] LoFirst = 16'hDC00;
  localparam logic [15:0] LoLast  = 16'hDFFF;
  localparam logic [20:0] SuppBase = 21'h10000;
  localparam int unsigned CpW = 21;

  // One queue entry: an optional held high surrogate (always three bytes)
  // followed by an optional main code point. last_idx is byte count - 1.
  typedef struct packed {
    logic           has_prev;
    logic [9:0]     prev_bits;
    logic           has_main;
    logic [CpW-1:0] main_cp;
    logic [1:0]     main_last_idx;
    logic           string_end;
  } job_t;

  function automatic logic [1:0] cp_last_idx(input logic [CpW-1:0] cp);
    logic [1:0] n;
    if (cp < 21'h80) begin
      n = 2'd0;
    end else if (cp < 21'h800) begin
      n = 2'd1;
    end else if (cp < SuppBase) begin
      n = 2'd2;
    end else begin
      n = 2'd3;
    end
    return n;
  endfunction

  function automatic logic [7:0] enc_byte(input logic [CpW-1:0] cp,
                                          input logic [1:0] last_idx,
                                          input logic [1:0] idx);
    logic [1:0] k;
    logic [5:0] six;
    logic [7:0] b;
    k = last_idx - idx;
    case (k)
      2'd0:    six = cp[5:0];
      2'd1:    six = cp[11:6];
      2'd2:    six = cp[17:12];
      default: six = {3'b000, cp[20:18]};
    endcase
    if (idx == 2'd0) begin
      case (last_idx)
        2'd0:    b = {1'b0, cp[6:0]};
        2'd1:    b = {3'b110, cp[10:6]};
        2'd2:    b = {4'b1110, cp[15:12]};
        default: b = {5'b11110, cp[20:18]};
      endcase
    end else begin
      b = {2'b10, six};
    end
    return b;
  endfunction

endpackage

@@ sv/u16u8_front.sv @@
module u16u8_front
  import u16u8_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] code_unit_i,
  input  logic        last_unit_i,
  input  logic        q_full_i,
  output logic        push_o,
  output job_t        job_o
);

  logic       pend_valid_q, pend_valid_d;
  logic [9:0] pend_bits_q, pend_bits_d;
  logic       accept;
  logic       is_hi, is_lo;
  logic [CpW-1:0] supp_cp;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    is_hi   = code_unit_i inside {[HiFirst:HiLast]};
    is_lo   = code_unit_i inside {[LoFirst:LoLast]};
    supp_cp = {1'b0, pend_bits_q, code_unit_i[9:0]} + SuppBase;
  end

  always_comb begin
    job_o            = '0;
    job_o.string_end = last_unit_i;
    pend_valid_d     = pend_valid_q;
    pend_bits_d      = pend_bits_q;
    if (pend_valid_q && is_lo) begin
      job_o.has_main      = 1'b1;
      job_o.main_cp       = supp_cp;
      job_o.main_last_idx = 2'd3;
      pend_valid_d        = 1'b0;
      pend_bits_d         = '0;
    end else begin
      job_o.has_prev  = pend_valid_q;
      job_o.prev_bits = pend_bits_q;
      if (is_hi && !last_unit_i) begin
        pend_valid_d = 1'b1;
        pend_bits_d  = code_unit_i[9:0];
      end else begin
        job_o.has_main      = 1'b1;
        job_o.main_cp       = {5'b00000, code_unit_i};
        job_o.main_last_idx = cp_last_idx({5'b00000, code_unit_i});
        pend_valid_d        = 1'b0;
        pend_bits_d         = '0;
      end
    end
    // a newly held high surrogate pushes nothing unless an older one is flushed
    push_o = accept && (job_o.has_prev || job_o.has_main);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      pend_bits_q  <= '0;
    end else if (accept) begin
      pend_valid_q <= pend_valid_d;
      pend_bits_q  <= pend_bits_d;
    end
  end

endmodule

@@ sv/u16u8_queue.sv @@
module u16u8_queue
  import u16u8_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wrap_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= wrap_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

@@ sv/u16u8_back.sv @@
module u16u8_back
  import u16u8_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  job_t       head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_end_o,
  output logic       string_end_o
);

  localparam logic PhasePrev = 1'b0;
  localparam logic PhaseMain = 1'b1;

  logic           phase_q, phase_d;
  logic [1:0]     idx_q, idx_d;
  logic           out_valid_q, out_valid_d;
  logic [7:0]     byte_q;
  logic           run_end_q, string_end_q;
  logic           load, step, cur_is_prev, cur_done, job_done;
  logic [CpW-1:0] cur_cp;
  logic [1:0]     cur_last;
  logic [7:0]     cur_byte;

  assign load = !out_valid_q || out_ready_i;
  assign step = load && !q_empty_i;

  always_comb begin
    cur_is_prev = head_i.has_prev && (phase_q == PhasePrev);
    if (cur_is_prev) begin
      cur_cp   = {5'b00000, HiFirst[15:10], head_i.prev_bits};
      cur_last = 2'd2;
    end else begin
      cur_cp   = head_i.main_cp;
      cur_last = head_i.main_last_idx;
    end
    cur_byte = enc_byte(cur_cp, cur_last, idx_q);
    cur_done = (idx_q == cur_last);
    job_done = cur_done && (!cur_is_prev || !head_i.has_main);
    pop_o    = step && job_done;

    phase_d = phase_q;
    idx_d   = idx_q;
    if (step) begin
      if (job_done) begin
        phase_d = PhasePrev;
        idx_d   = '0;
      end else if (cur_done) begin
        phase_d = PhaseMain;
        idx_d   = '0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end

    if (step) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhasePrev;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      byte_q       <= cur_byte;
      run_end_q    <= job_done;
      string_end_q <= job_done && head_i.string_end;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = byte_q;
  assign run_end_o    = run_end_q;
  assign string_end_o = string_end_q;

endmodule

@@ sv/utf16_to_utf8_transcoder.sv @@
// UTF-16 to UTF-8 transcoder. Each input item is one code unit; a unit is
// taken whenever the job queue has room, and the output side emits one
// UTF-8 byte per cycle from its output register while the queue holds a job
// and out_ready_i allows. Each BMP unit yields 1 to 3 bytes, a surrogate pair
// 4 (the high half itself yields no byte while held), and up to 6 bytes come
// out when a held high surrogate is flushed by a following unit. The
// queue (QueueDepth entries) absorbs bursts so input and output stall apart.
// run_end_o marks the last byte of each queue job, string_end_o the last byte
// of a job that carried last_unit_i.
module utf16_to_utf8_transcoder
  import u16u8_pkg::*;
#(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] code_unit_i,
  input  logic        last_unit_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        run_end_o,
  output logic        string_end_o
);

  logic push, q_full, q_empty, pop;
  job_t push_job, head_job;

  u16u8_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .code_unit_i (code_unit_i),
    .last_unit_i (last_unit_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .job_o       (push_job)
  );

  u16u8_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .head_o      (head_job)
  );

  u16u8_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .head_i       (head_job),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .run_end_o    (run_end_o),
    .string_end_o (string_end_o)
  );

endmodule

@@ sv/u16u8_checker.sv @@
`include "utf16_to_utf8_transcoder_macros.svh"

module u16u8_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  out_byte_o,
  input logic        run_end_o,
  input logic        string_end_o
);

  `U16U8_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_byte_o))
  `U16U8_ASSERT_NOW(a_str_end_run_end, out_valid_o && string_end_o, run_end_o)
  `U16U8_ASSERT_NOW(a_ascii_single, out_valid_o && !out_byte_o[7], run_end_o)
  // bytes of one item leave back to back once the first is taken
  `U16U8_ASSERT_NEXT(a_run_contig, out_valid_o && out_ready_i && !run_end_o, out_valid_o)
  `U16U8_ASSERT_NOW(a_cont_not_last_lead, out_valid_o && out_byte_o[7:6] == 2'b11, !run_end_o)

endmodule

bind utf16_to_utf8_transcoder u16u8_checker u_checker (.*);

@@ test/tb_utf16_to_utf8_transcoder.sv @@
module tb_utf16_to_utf8_transcoder;
  import u16u8_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned TailCycles = 20;

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       string_end;
  } utf8_byte_t;

  logic        clk;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [15:0] code_unit_i;
  logic        last_unit_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  out_byte_o;
  logic        run_end_o;
  logic        string_end_o;

  // predictor state: held high surrogate
  logic        held_valid;
  logic [9:0]  held_bits;

  utf8_byte_t  utf8_expected_q[$];
  logic [7:0]  step_bytes[$];

  bit          no_idle;
  int unsigned error_cnt;
  int unsigned cycle_cnt;
  int unsigned units_sent;
  int unsigned pairs_seen;
  int unsigned strings_seen;
  int unsigned bytes_checked;

  utf16_to_utf8_transcoder u_top (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .code_unit_i  (code_unit_i),
    .last_unit_i  (last_unit_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .run_end_o    (run_end_o),
    .string_end_o (string_end_o)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------
  task automatic append_code_point(input logic [20:0] cp);
    if (cp < 21'h80) begin
      step_bytes.push_back({1'b0, cp[6:0]});
    end else if (cp < 21'h800) begin
      step_bytes.push_back({3'b110, cp[10:6]});
      step_bytes.push_back({2'b10, cp[5:0]});
    end else if (cp < SuppBase) begin
      step_bytes.push_back({4'b1110, cp[15:12]});
      step_bytes.push_back({2'b10, cp[11:6]});
      step_bytes.push_back({2'b10, cp[5:0]});
    end else begin
      step_bytes.push_back({5'b11110, cp[20:18]});
      step_bytes.push_back({2'b10, cp[17:12]});
      step_bytes.push_back({2'b10, cp[11:6]});
      step_bytes.push_back({2'b10, cp[5:0]});
    end
  endtask

  task automatic predict_utf8(input logic [15:0] unit, input logic last);
    logic        is_hi;
    logic        is_lo;
    logic [20:0] cp;
    int          n;
    utf8_byte_t  e;
    step_bytes.delete();
    is_hi = (unit >= HiFirst) && (unit <= HiLast);
    is_lo = (unit >= LoFirst) && (unit <= LoLast);
    if (held_valid && is_lo) begin
      cp = SuppBase + 21'({held_bits, 10'd0}) + 21'(unit[9:0]);
      held_valid = 1'b0;
      held_bits  = '0;
      pairs_seen++;
      append_code_point(cp);
    end else begin
      if (held_valid) begin
        // held high half gets flushed on its own
        append_code_point(21'(HiFirst | 16'(held_bits)));
        held_valid = 1'b0;
        held_bits  = '0;
      end
      if (is_hi && !last) begin
        held_valid = 1'b1;
        held_bits  = unit[9:0];
      end else begin
        append_code_point(21'(unit));
      end
    end
    n = step_bytes.size();
    for (int k = 0; k < n; k++) begin
      e.data       = step_bytes[k];
      e.run_end    = (k == n - 1);
      e.string_end = (k == n - 1) && last;
      utf8_expected_q.push_back(e);
    end
    if (last) strings_seen++;
  endtask

  // ---------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------
  // Entered and left at a falling edge; valid may drop before an item.
  task automatic send_unit(input logic [15:0] unit, input logic last);
    if (!no_idle && ($urandom_range(0, 5) == 0)) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid_i  = 1'b1;
    code_unit_i = unit;
    last_unit_i = last;
    do @(posedge clk); while (!in_ready_o);
    predict_utf8(unit, last);
    units_sent++;
    @(negedge clk);
  endtask

  task automatic wait_output_drained();
    while (utf8_expected_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    int unsigned stall_left;
    out_ready_i = 1'b0;
    stall_left  = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready_i = 1'b0;
        stall_left--;
      end else if (!no_idle && ($urandom_range(0, 7) == 0)) begin
        out_ready_i = 1'b0;
        stall_left  = $urandom_range(1, 13) - 1;
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : byte_checker
    utf8_byte_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      bytes_checked++;
      if (utf8_expected_q.size() == 0) begin
        error_cnt++;
        $display("%0t: unexpected byte: expected none, actual %h run_end %b string_end %b",
                 $time, out_byte_o, run_end_o, string_end_o);
      end else begin
        e = utf8_expected_q.pop_front();
        if (out_byte_o !== e.data) begin
          error_cnt++;
          $display("%0t: out_byte expected %h actual %h", $time, e.data, out_byte_o);
        end
        if (run_end_o !== e.run_end) begin
          error_cnt++;
          $display("%0t: run_end expected %b actual %b", $time, e.run_end, run_end_o);
        end
        if (string_end_o !== e.string_end) begin
          error_cnt++;
          $display("%0t: string_end expected %b actual %b", $time, e.string_end,
                   string_end_o);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  task automatic test_length_boundaries();
    send_unit(16'h0000, 1'b1);
    send_unit(16'h007F, 1'b0);
    send_unit(16'h0080, 1'b0);
    send_unit(16'h07FF, 1'b0);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hD7FF, 1'b0);
    send_unit(16'hE000, 1'b0);
    send_unit(16'hFFFF, 1'b1);
  endtask

  task automatic test_surrogate_pairs();
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDC00, 1'b1);
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'hDFFF, 1'b0);
    send_unit(16'h0041, 1'b1);
  endtask

  task automatic test_unpaired_surrogates();
    // lone lows
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hDFFF, 1'b1);
    // held high then plain unit: flush plus the unit
    send_unit(16'hD800, 1'b0);
    send_unit(16'h0041, 1'b0);
    send_unit(16'hDA55, 1'b0);
    send_unit(16'hFFFF, 1'b1);
    // high at end of string goes out alone
    send_unit(16'hDBFF, 1'b1);
    // high after high: first flushed, second held, then paired
    send_unit(16'hD801, 1'b0);
    send_unit(16'hDA00, 1'b0);
    send_unit(16'hDC05, 1'b1);
    // held high then high at end: both flushed
    send_unit(16'hD9AA, 1'b0);
    send_unit(16'hDB33, 1'b1);
  endtask

  task automatic send_random_string();
    int unsigned len;
    int unsigned pos;
    logic [15:0] unit;
    logic        at_end;
    len = $urandom_range(1, 8);
    pos = 0;
    while (pos < len) begin
      at_end = (pos == len - 1);
      case ($urandom_range(0, 9))
        0, 1: unit = 16'($urandom_range(16'h0000, 16'h007F));
        2:    unit = 16'($urandom_range(16'h0080, 16'h07FF));
        3, 4: begin
          if ($urandom_range(0, 1) == 0) begin
            unit = 16'($urandom_range(16'h0800, 16'hD7FF));
          end else begin
            unit = 16'($urandom_range(16'hE000, 16'hFFFF));
          end
        end
        5, 6: begin
          if (!at_end) begin
            send_unit(16'($urandom_range(HiFirst, HiLast)), 1'b0);
            pos++;
            at_end = (pos == len - 1);
          end
          unit = 16'($urandom_range(LoFirst, LoLast));
        end
        7:    unit = 16'($urandom_range(HiFirst, HiLast));
        8:    unit = 16'($urandom_range(LoFirst, LoLast));
        default: unit = 16'($urandom());
      endcase
      send_unit(unit, at_end);
      pos++;
    end
  endtask

  task automatic test_random_strings(input int unsigned unit_target);
    while (units_sent < unit_target) send_random_string();
  endtask

  task automatic test_drain_pause();
    in_valid_i = 1'b0;
    wait_output_drained();
    repeat ($urandom_range(1, 13)) @(negedge clk);
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    code_unit_i   = '0;
    last_unit_i   = 1'b0;
    held_valid    = 1'b0;
    held_bits     = '0;
    no_idle       = 1'b0;
    error_cnt     = 0;
    units_sent    = 0;
    pairs_seen    = 0;
    strings_seen  = 0;
    bytes_checked = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;
    @(negedge clk);

    test_length_boundaries();
    test_surrogate_pairs();
    test_unpaired_surrogates();
    test_random_strings(units_sent + 45);
    test_drain_pause();
    test_random_strings(units_sent + 20);
    no_idle = 1'b1;
    test_random_strings(units_sent + 25);

    in_valid_i = 1'b0;
    wait_output_drained();
    repeat (TailCycles) @(posedge clk);
    if (utf8_expected_q.size() != 0) begin
      error_cnt++;
      $display("%0t: %0d expected bytes never arrived", $time, utf8_expected_q.size());
    end

    $display("Sent %0d code units in %0d strings, %0d surrogate pairs combined,",
             units_sent, strings_seen, pairs_seen);
    $display("and checked %0d UTF-8 bytes over %0d cycles.", bytes_checked, cycle_cnt);
    if (error_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ utf16_to_utf8_transcoder.f @@
+incdir+sv
sv/u16u8_pkg.sv
sv/u16u8_front.sv
sv/u16u8_queue.sv
sv/u16u8_back.sv
sv/utf16_to_utf8_transcoder.sv
sv/u16u8_checker.sv
test/tb_utf16_to_utf8_transcoder.sv
